>>> hdl/hnt_pkg.sv
package hnt_pkg;

  localparam int COLS_CFG_W = 11;
  localparam int ROWS_CFG_W = 13;
  localparam int STEP_W     = 16;
  localparam int UNIT_W     = 16;
  localparam int ROW_OUT_W  = 12;
  localparam int COL_OUT_W  = 10;
  localparam int CFG_IDX_W  = 2;

  // Quotient and root widths of the normaliser: F = v^2 * 2^30 / S never exceeds 2^30.
  localparam int QUOT_W = 31;
  localparam int ROOT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_STEP    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hdl/hnt_fifo.sv
module hnt_fifo #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     din,
  input  logic             pop,
  output logic [W-1:0]     dout,
  output hnt_pkg::q_stat_t stat
);
  import hnt_pkg::*;

  logic [W-1:0] entry [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign dout       = entry[rp];
  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);

endmodule

>>> hdl/hnt_front.sv
module hnt_front #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 4096,
  parameter int HEIGHT_BITS = 16,
  localparam int JOB_W      = 2 * (HEIGHT_BITS + 1) + 17 + 22
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [HEIGHT_BITS-1:0]       height,
  input  logic [hnt_pkg::COLS_CFG_W-1:0]      columns_in_use,
  input  logic [hnt_pkg::ROWS_CFG_W-1:0]      rows_in_use,
  input  logic [hnt_pkg::STEP_W-1:0]          spatial_step,
  input  hnt_pkg::q_stat_t                    q_stat,
  output logic                                push,
  output logic [JOB_W-1:0]                    job
);
  import hnt_pkg::*;

  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int RNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CCMP_W = (CNT_W > COLS_CFG_W) ? CNT_W : COLS_CFG_W;
  localparam int RCMP_W = (RNT_W > ROWS_CFG_W) ? RNT_W : ROWS_CFG_W;
  localparam int DW     = HEIGHT_BITS + 1;

  typedef enum logic {F_IDLE, F_WORK} fstate_t;

  fstate_t state;
  logic              sel;
  logic [CW-1:0]     col_cnt;
  logic [RW-1:0]     row_cnt;
  logic signed [HEIGHT_BITS-1:0] recent;
  logic signed [HEIGHT_BITS-1:0] x_reg;
  logic signed [HEIGHT_BITS-1:0] bot_reg;
  logic [CW-1:0]     c_reg;
  logic [RW-1:0]     r_reg;
  logic              row_end;
  logic              interior;

  logic [HEIGHT_BITS-1:0] mem0 [MAX_COLS];
  logic [HEIGHT_BITS-1:0] mem1 [MAX_COLS];
  logic [HEIGHT_BITS-1:0] d0a, d0b, d1a, d1b;

  logic [CCMP_W-1:0] cols_ext;
  logic [RCMP_W-1:0] rows_ext;
  logic [CNT_W-1:0]  cols;
  logic [RNT_W-1:0]  rows;
  logic [CW-1:0]     c_eff;
  logic [RW-1:0]     r_eff;
  logic [CW-1:0]     c_m1, c_m2;
  logic [CW-1:0]     ra0a, ra1a;
  logic              acc;
  logic              work_go;
  logic              we;
  logic [CW-1:0]     wa;
  logic [HEIGHT_BITS-1:0] wd;
  logic signed [HEIGHT_BITS-1:0] top, right, left;
  logic signed [DW-1:0] a_diff, c_diff;
  logic [31:0]       row_m1, col_m1;

  always_comb begin
    cols_ext = CCMP_W'(columns_in_use);
    rows_ext = RCMP_W'(rows_in_use);
    if (cols_ext < CCMP_W'(3)) begin
      cols = CNT_W'(3);
    end else if (cols_ext > CCMP_W'(MAX_COLS)) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(cols_ext);
    end
    if (rows_ext < RCMP_W'(3)) begin
      rows = RNT_W'(3);
    end else if (rows_ext > RCMP_W'(MAX_ROWS)) begin
      rows = RNT_W'(MAX_ROWS);
    end else begin
      rows = RNT_W'(rows_ext);
    end
  end

  // A counter left beyond a shortened row or frame counts as the last one.
  assign c_eff = (CNT_W'(col_cnt) >= cols) ? CW'(cols - CNT_W'(1)) : col_cnt;
  assign r_eff = (RNT_W'(row_cnt) >= rows) ? RW'(rows - RNT_W'(1)) : row_cnt;
  assign c_m1  = c_eff - CW'(1);
  assign c_m2  = c_eff - CW'(2);

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != F_IDLE);
  assign work_go  = (state == F_WORK) && (!interior || !q_stat.full);
  assign push     = work_go && interior;

  // The buffer selected by sel holds the older row and is refilled with the current one.
  assign ra0a = sel ? c_eff : c_m1;
  assign ra1a = sel ? c_m1 : c_eff;

  assign we = (acc && (c_eff != CW'(0))) || (work_go && row_end);
  assign wa = acc ? c_m1 : c_reg;
  assign wd = acc ? recent : x_reg;

  always_ff @(posedge clk) begin
    if (acc) begin
      d0a <= mem0[ra0a];
      d0b <= mem0[c_m2];
    end
    if (we && !sel) begin
      mem0[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      d1a <= mem1[ra1a];
      d1b <= mem1[c_m2];
    end
    if (we && sel) begin
      mem1[wa] <= wd;
    end
  end

  assign top   = sel ? d1a : d0a;
  assign right = sel ? d0a : d1a;
  assign left  = sel ? d0b : d1b;

  assign a_diff = DW'(left) - DW'(right);
  assign c_diff = DW'(bot_reg) - DW'(top);
  assign row_m1 = 32'(r_reg) - 32'd1;
  assign col_m1 = 32'(c_reg) - 32'd1;
  assign job    = {a_diff, c_diff, {spatial_step, 1'b0},
                   row_m1[ROW_OUT_W-1:0], col_m1[COL_OUT_W-1:0]};

  always_ff @(posedge clk) begin
    if (acc) begin
      x_reg    <= height;
      bot_reg  <= recent;
      c_reg    <= c_eff;
      r_reg    <= r_eff;
      row_end  <= (CNT_W'(c_eff) + CNT_W'(1) >= cols);
      interior <= (c_eff >= CW'(2)) && (r_eff >= RW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      sel     <= 1'b0;
      col_cnt <= '0;
      row_cnt <= '0;
      recent  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (acc) begin
            recent <= height;
            state  <= F_WORK;
          end
        end
        F_WORK: begin
          if (work_go) begin
            if (row_end) begin
              sel     <= ~sel;
              col_cnt <= '0;
              row_cnt <= (RNT_W'(r_reg) + RNT_W'(1) >= rows) ? '0 : r_reg + RW'(1);
            end else begin
              col_cnt <= c_reg + CW'(1);
              row_cnt <= r_reg;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/hnt_back.sv
module hnt_back #(
  parameter int HEIGHT_BITS = 16,
  localparam int JOB_W      = 2 * (HEIGHT_BITS + 1) + 17 + 22
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [JOB_W-1:0]                     job,
  input  hnt_pkg::q_stat_t                     q_stat,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [hnt_pkg::UNIT_W-1:0]    normal_x,
  output logic signed [hnt_pkg::UNIT_W-1:0]    normal_y,
  output logic signed [hnt_pkg::UNIT_W-1:0]    normal_z,
  output logic signed [hnt_pkg::UNIT_W-1:0]    tangent_x,
  output logic signed [hnt_pkg::UNIT_W-1:0]    tangent_y,
  output logic [hnt_pkg::ROW_OUT_W-1:0]        point_row,
  output logic [hnt_pkg::COL_OUT_W-1:0]        point_col
);
  import hnt_pkg::*;

  localparam int DW   = HEIGHT_BITS + 1;
  localparam int TS_W = STEP_W + 1;
  localparam int MW   = (HEIGHT_BITS > TS_W) ? HEIGHT_BITS : TS_W;
  localparam int CPW  = MW + 1;
  localparam int SQ_W = 2 * MW;
  localparam int S_W  = SQ_W + 2;

  typedef enum logic [2:0] {B_IDLE, B_SQ, B_DIV, B_SQRT, B_HOLD} bstate_t;

  bstate_t state;
  logic signed [DW-1:0]  ja, jc;
  logic [TS_W-1:0]       jts;
  logic [ROW_OUT_W-1:0]  jrow;
  logic [COL_OUT_W-1:0]  jcol;
  logic                  vec;
  logic [1:0]            k;
  logic [4:0]            step;
  logic [3:0]            bitn;
  logic [SQ_W-1:0]       sq [3];
  logic [S_W-1:0]        sum_sq;
  logic [S_W-1:0]        rem;
  logic [QUOT_W-1:0]     quot;
  logic [ROOT_W-1:0]     root;
  logic signed [UNIT_W-1:0] res [5];

  logic signed [CPW-1:0] comp_a, comp_na, comp_c, comp_ts, cur;
  logic [MW-1:0]         mag;
  logic [SQ_W-1:0]       prod;
  logic [S_W:0]          trial;
  logic                  ge;
  logic [ROOT_W-1:0]     trial_r;
  logic [2*ROOT_W-1:0]   sqr;
  logic [ROOT_W-1:0]     root_next;
  logic [ROOT_W:0]       q_wide;
  logic signed [UNIT_W-1:0] q_val, q_signed;
  logic [1:0]            last_k;
  logic [2:0]            res_idx;

  assign comp_a  = CPW'(ja);
  assign comp_na = -comp_a;
  assign comp_c  = CPW'(jc);
  assign comp_ts = CPW'(signed'({1'b0, jts}));

  // Normal is (a, 2*step, c) and tangent is (2*step, -a, 0).
  always_comb begin
    unique case ({vec, k})
      3'b000:  cur = comp_a;
      3'b001:  cur = comp_ts;
      3'b010:  cur = comp_c;
      3'b100:  cur = comp_ts;
      3'b101:  cur = comp_na;
      default: cur = '0;
    endcase
  end

  assign mag  = cur[CPW-1] ? MW'(-cur) : MW'(cur);
  assign prod = SQ_W'(mag) * SQ_W'(mag);

  // Restoring division step: the numerator is sq * 2^30, whose only set low bit is sq[0].
  assign trial = {rem, (step == 5'd1) ? sq[k][0] : 1'b0};
  assign ge    = (trial >= (S_W + 1)'(sum_sq));

  assign trial_r   = root | (ROOT_W'(1) << bitn);
  assign sqr       = (2 * ROOT_W)'(trial_r) * (2 * ROOT_W)'(trial_r);
  assign root_next = (sqr <= (2 * ROOT_W)'(quot)) ? trial_r : root;

  // Largest q with 2q-1 not above the root gives round to nearest.
  assign q_wide   = ((ROOT_W + 1)'(root_next) + (ROOT_W + 1)'(1)) >> 1;
  assign q_val    = UNIT_W'(q_wide);
  assign q_signed = (sum_sq == '0) ? '0 : (cur[CPW-1] ? -q_val : q_val);

  assign last_k  = vec ? 2'd1 : 2'd2;
  assign res_idx = vec ? 3'(k) + 3'd3 : 3'(k);
  assign pop     = (state == B_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      vec       <= 1'b0;
      k         <= 2'd0;
      step      <= 5'd0;
      bitn      <= 4'd0;
    end else begin
      if (out_valid && !out_stall && (state != B_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            {ja, jc, jts, jrow, jcol} <= job;
            vec   <= 1'b0;
            k     <= 2'd0;
            state <= B_SQ;
          end
        end
        B_SQ: begin
          sq[k]  <= prod;
          sum_sq <= ((k == 2'd0) ? '0 : sum_sq) + S_W'(prod);
          if (k == 2'd2) begin
            k     <= 2'd0;
            step  <= 5'd0;
            state <= B_DIV;
          end else begin
            k <= k + 2'd1;
          end
        end
        B_DIV: begin
          if (step == 5'd0) begin
            rem <= S_W'(sq[k] >> 1);
          end else begin
            rem  <= ge ? S_W'(trial - (S_W + 1)'(sum_sq)) : S_W'(trial);
            quot <= {quot[QUOT_W-2:0], ge};
          end
          if (step == 5'd31) begin
            root  <= '0;
            bitn  <= 4'd15;
            state <= B_SQRT;
          end else begin
            step <= step + 5'd1;
          end
        end
        B_SQRT: begin
          root <= root_next;
          if (bitn == 4'd0) begin
            res[res_idx] <= q_signed;
            if (k == last_k) begin
              if (vec) begin
                state <= B_HOLD;
              end else begin
                vec   <= 1'b1;
                k     <= 2'd0;
                state <= B_SQ;
              end
            end else begin
              k     <= k + 2'd1;
              step  <= 5'd0;
              state <= B_DIV;
            end
          end else begin
            bitn <= bitn - 4'd1;
          end
        end
        B_HOLD: begin
          if (!out_valid || !out_stall) begin
            normal_x  <= res[0];
            normal_y  <= res[1];
            normal_z  <= res[2];
            tangent_x <= res[3];
            tangent_y <= res[4];
            point_row <= jrow;
            point_col <= jcol;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/heightmap_normal_tangent.sv
// Height-field normal and tangent unit.
// Samples arrive on the input channel (in_valid, in_stall, height) in raster
// order; a transfer happens when in_valid is high and in_stall is low. The
// front reads the two line buffers and writes back the previous sample in the
// transfer cycle, then stalls input until the counters and, at a row end,
// the buffer are updated; an interior point also needs room in the queue.
// Each interior point is queued (two entries) for the back, a shared divide
// and square-root unit that works one bit per cycle. It squares and sums the
// normal's components, divides each by the sum and takes the root, repeats
// this for the tangent and loads the output. Border samples stay in the front.
// Point (r-1, c-1) leaves after sample (r, c).
// Results appear on out_valid with the normal, tangent and point fields held
// in an output register; while out_stall is high they hold, the back can
// finish the next point and the queue keeps absorbing samples until full.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always ready and should be made only while the block is idle.
// Reset empties the queue and output, clears counters and the previous
// sample, and restores 1024 columns, 4096 rows and a spacing of 1.0.
module heightmap_normal_tangent #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 4096,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [HEIGHT_BITS-1:0]        height,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [hnt_pkg::UNIT_W-1:0]    normal_x,
  output logic signed [hnt_pkg::UNIT_W-1:0]    normal_y,
  output logic signed [hnt_pkg::UNIT_W-1:0]    normal_z,
  output logic signed [hnt_pkg::UNIT_W-1:0]    tangent_x,
  output logic signed [hnt_pkg::UNIT_W-1:0]    tangent_y,
  output logic [hnt_pkg::ROW_OUT_W-1:0]        point_row,
  output logic [hnt_pkg::COL_OUT_W-1:0]        point_col,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hnt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hnt_pkg::STEP_W-1:0]           cfg_data
);
  import hnt_pkg::*;

  localparam int JOB_W = 2 * (HEIGHT_BITS + 1) + 17 + 22;

  logic [COLS_CFG_W-1:0] columns_in_use;
  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [STEP_W-1:0]     spatial_step;
  q_stat_t               q_stat;
  logic                  push;
  logic                  pop;
  logic [JOB_W-1:0]      job_in;
  logic [JOB_W-1:0]      job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLS_CFG_W'(1024);
      rows_in_use    <= ROWS_CFG_W'(4096);
      spatial_step   <= STEP_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLUMNS: columns_in_use <= cfg_data[COLS_CFG_W-1:0];
        CFG_ROWS:    rows_in_use    <= cfg_data[ROWS_CFG_W-1:0];
        CFG_STEP:    spatial_step   <= cfg_data;
        default:     ;
      endcase
    end
  end

  hnt_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .height        (height),
    .columns_in_use(columns_in_use),
    .rows_in_use   (rows_in_use),
    .spatial_step  (spatial_step),
    .q_stat        (q_stat),
    .push          (push),
    .job           (job_in)
  );

  hnt_fifo #(
    .W(JOB_W)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .din (job_in),
    .pop (pop),
    .dout(job_out),
    .stat(q_stat)
  );

  hnt_back #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_out),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .tangent_x(tangent_x),
    .tangent_y(tangent_y),
    .point_row(point_row),
    .point_col(point_col)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("point queued while the queue is full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("point taken from an empty queue");

  a_front_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front took a second sample before finishing the first");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hnt_pkg::*;

  typedef struct {
    logic signed [UNIT_W-1:0]  nx, ny, nz, tx, ty;
    logic [ROW_OUT_W-1:0]      prow;
    logic [COL_OUT_W-1:0]      pcol;
  } surface_point_t;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 4096;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [UNIT_W-1:0] normal_x, normal_y, normal_z, tangent_x, tangent_y;
  logic [ROW_OUT_W-1:0] point_row;
  logic [COL_OUT_W-1:0] point_col;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;

  heightmap_normal_tangent dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .height(height),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .tangent_x(tangent_x), .tangent_y(tangent_y),
    .point_row(point_row), .point_col(point_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's state, updated on every transfer.
  logic [COLS_CFG_W-1:0] cols_reg = 11'd1024;
  logic [ROWS_CFG_W-1:0] rows_reg = 13'd4096;
  logic [STEP_W-1:0]     step_reg = 16'd4096;
  int older_line [MAX_COLS];
  int newer_line [MAX_COLS];
  int col_pos = 0;
  int row_pos = 0;
  int prev_height = 0;

  logic signed [15:0] sample_q [$];
  surface_point_t     pending_points [$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_pct = 0;
  int  cycle_cnt = 0;

  function automatic int cols_eff();
    return (cols_reg < 3) ? 3 : (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int rows_eff();
    return (rows_reg < 3) ? 3 : (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  // Rounded Q1.14 component: largest q with (q - 1/2)^2 * S <= v^2 * 2^28.
  function automatic logic [15:0] unit_part(longint v, longint unsigned s);
    longint unsigned mag, q, t, d;
    bit [127:0] lim, lhs;
    if (s == 0) return '0;
    mag = (v < 0) ? -v : v;
    lim = 128'(mag * mag) << 30;
    q = 0;
    for (int b = 15; b >= 0; b--) begin
      t = q | (64'd1 << b);
      d = 2 * t - 1;
      lhs = 128'(d * d) * 128'(s);
      if (lhs <= lim) q = t;
    end
    if (v < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic void take_height(logic signed [15:0] h);
    int c, r, tmp;
    longint up, rt, lf, dn, two_step, a, bb;
    longint unsigned s;
    surface_point_t pt;
    c = col_pos;
    r = row_pos;
    if (c >= cols_eff()) c = cols_eff() - 1;
    if (r >= rows_eff()) r = rows_eff() - 1;
    if (r >= 2 && c >= 2) begin
      up = older_line[c-1];
      rt = newer_line[c];
      lf = newer_line[c-2];
      dn = prev_height;
      two_step = 2 * longint'(step_reg);
      a = lf - rt;
      bb = dn - up;
      s = a * a + two_step * two_step + bb * bb;
      pt.nx = unit_part(a, s);
      pt.ny = unit_part(two_step, s);
      pt.nz = unit_part(bb, s);
      s = two_step * two_step + a * a;
      pt.tx = unit_part(two_step, s);
      pt.ty = unit_part(-a, s);
      pt.prow = ROW_OUT_W'(r - 1);
      pt.pcol = COL_OUT_W'(c - 1);
      pending_points.push_back(pt);
    end
    if (c >= 1) older_line[c-1] = prev_height;
    prev_height = h;
    if (c + 1 >= cols_eff()) begin
      older_line[c] = h;
      for (int i = 0; i < MAX_COLS; i++) begin
        tmp = older_line[i];
        older_line[i] = newer_line[i];
        newer_line[i] = tmp;
      end
      col_pos = 0;
      row_pos = (r + 1 >= rows_eff()) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic bit field_ok(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      height <= '0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() > 0) begin
        in_valid <= 1'b1;
        height <= sample_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at a randomly redrawn density, sometimes none at all.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct <= 0;
        2: stall_pct <= 20;
        3: stall_pct <= 50;
        default: stall_pct <= 90;
      endcase
    end
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk) begin
    surface_point_t e;
    bit ok;
    if (!rst) begin
      if (in_valid && !in_stall) take_height(height);
      if (out_valid && !out_stall) begin
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected result at row %0d col %0d", $time, point_row, point_col);
          errors++;
        end else begin
          e = pending_points.pop_front();
          ok = field_ok("normal_x", e.nx, normal_x);
          ok &= field_ok("normal_y", e.ny, normal_y);
          ok &= field_ok("normal_z", e.nz, normal_z);
          ok &= field_ok("tangent_x", e.tx, tangent_x);
          ok &= field_ok("tangent_y", e.ty, tangent_y);
          ok &= field_ok("point_row", e.prow, point_row);
          ok &= field_ok("point_col", e.pcol, point_col);
          if (!ok) errors++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [STEP_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COLUMNS: cols_reg = val[COLS_CFG_W-1:0];
      CFG_ROWS:    rows_reg = val[ROWS_CFG_W-1:0];
      default:     step_reg = val;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_valid || pending_points.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_height(logic signed [15:0] last);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($signed($urandom_range(0, 128)) - 64);
      2: return last;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frames(int frames, bit pause_midway);
    int n;
    logic signed [15:0] last;
    n = frames * cols_eff() * rows_eff();
    last = '0;
    for (int i = 0; i < n; i++) begin
      last = random_height(last);
      sample_q.push_back(last);
      // Midway, queue nothing more until the sender and all results are done.
      if (pause_midway && i == n / 2)
        while (sample_q.size() > 0 || in_valid || pending_points.size() > 0)
          @(posedge clk);
    end
  endtask

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(0, 3))
      0: return 16'd1;
      1: return 16'hffff;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    int sent;
    for (int i = 0; i < MAX_COLS; i++) begin
      older_line[i] = 0;
      newer_line[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Counts below the minimum are clamped to a 3 x 3 frame.
    write_reg(CFG_COLUMNS, 16'd0);
    write_reg(CFG_ROWS, 16'd2);
    write_reg(CFG_STEP, 16'd4096);
    sample_q.push_back(16'sh7fff); sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh7fff); sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh0000); sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh7fff); sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh8000);
    drain();

    // Zero spacing over a flat patch gives zero vectors.
    write_reg(CFG_COLUMNS, 16'd3);
    write_reg(CFG_ROWS, 16'd3);
    write_reg(CFG_STEP, 16'd0);
    repeat (9) sample_q.push_back(16'sd100);
    drain();

    write_reg(CFG_STEP, 16'hffff);
    sample_q.push_back(16'sh8000); sample_q.push_back(16'sh0000);
    sample_q.push_back(16'sh7fff); sample_q.push_back(16'sh7fff);
    sample_q.push_back(-16'sd1);   sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh0001); sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh0000);
    drain();

    // Widest row: an over-range count clamps to the maximum. Two full rows
    // and the start of the third are enough to reach interior points.
    write_reg(CFG_COLUMNS, 16'd2047);
    write_reg(CFG_ROWS, 16'd3);
    write_reg(CFG_STEP, 16'd1);
    for (int i = 0; i < 2 * MAX_COLS + 16; i++) sample_q.push_back(16'($urandom));
    drain();

    sent = 0;
    while (sent < 400) begin
      write_reg(CFG_COLUMNS, 16'($urandom_range(3, 12)));
      write_reg(CFG_ROWS, 16'($urandom_range(3, 8)));
      write_reg(CFG_STEP, random_step());
      random_frames($urandom_range(1, 3), sent == 0);
      sent += cols_eff() * rows_eff();
      drain();
    end

    // Tallest frame setting; only its first rows are streamed.
    write_reg(CFG_COLUMNS, 16'd3);
    write_reg(CFG_ROWS, 16'd8191);
    write_reg(CFG_STEP, random_step());
    for (int i = 0; i < 30; i++) sample_q.push_back(16'($urandom));
    drain();

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
